/* hw/rtl/att_pkg.sv */
package att_pkg;

   localparam int MODE_W   = 2;
   localparam int TIME_W   = 32;
   localparam int HANDLE_W = 4;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;

   localparam int MAX_FIRES  = 16;
   localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

   localparam logic [MODE_W-1:0] MODE_REGISTER   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UNREGISTER = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK       = 2'd2;

   localparam logic [STATUS_W-1:0] ST_REGISTERED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_ALARM   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FIRED      = 3'd5;

   typedef enum logic [2:0] {
      KIND_REG_OK,
      KIND_FULL,
      KIND_ZERO,
      KIND_REMOVED,
      KIND_NO_ALARM,
      KIND_FIRE,
      KIND_SUMMARY
   } kind_type;

   typedef struct packed {
      logic     latch;
      logic     scan_clr;
      logic     scan_inc;
      logic     rd_best;
      logic     mask_done;
      logic     tick_clr;
      logic     reg_write;
      logic     unreg_clear;
      logic     fire_commit;
      logic     emit;
      kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              period_zero;
      logic              handle_ok;
      logic              cur_free;
      logic              scan_last;
      logic              fire_ok;
      logic              out_free;
   } stat_type;

endpackage

/* hw/rtl/att_req_if.sv */
interface att_req_if;
   logic                           valid;
   logic                           ready;
   logic [att_pkg::MODE_W-1:0]     mode;
   logic [att_pkg::TIME_W-1:0]     now;
   logic [att_pkg::TIME_W-1:0]     period;
   logic                           repeat_req;
   logic [att_pkg::HANDLE_W-1:0]   handle;

   modport source (output valid, mode, now, period, repeat_req, handle, input ready);
   modport sink (input valid, mode, now, period, repeat_req, handle, output ready);
endinterface

/* hw/rtl/att_rsp_if.sv */
interface att_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [att_pkg::STATUS_W-1:0]   status;
   logic [att_pkg::SLOT_W-1:0]     slot;
   logic                           fired;
   logic [att_pkg::TIME_W-1:0]     next_delay;
   logic                           last;

   modport source (output valid, status, slot, fired, next_delay, last, input ready);
   modport sink (input valid, status, slot, fired, next_delay, last, output ready);
endinterface

/* hw/rtl/alarm_timer_table.sv */
// channel   modport  fields
// req_if    sink     mode, now, period, repeat_req, handle
// rsp_if    source   status, slot, fired, next_delay, last
//
// One transaction at a time. Register: a zero period is answered without a scan, else after a
// free-slot scan. Unregister: no scan. Tick with F fires: the due-time memory is scanned one
// slot per cycle, once per fire, once more, then once for the next delay.
// Synchronous reset clears the valid bits and control; no clearing pass.
// A result waits in the output register while rsp_if.ready is low; the block
// holds before writing the next result until that register is taken.
module alarm_timer_table #(
   parameter int NUM_SLOTS = 16
) (
   input  logic     clock,
   input  logic     reset,
   att_req_if.sink  req_if,
   att_rsp_if.source rsp_if
);

   att_pkg::cmd_type  cmd;
   att_pkg::stat_type stat;

   att_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   att_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_mode       (req_if.mode),
      .req_now        (req_if.now),
      .req_period     (req_if.period),
      .req_repeat_req (req_if.repeat_req),
      .req_handle     (req_if.handle),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_status     (rsp_if.status),
      .rsp_slot       (rsp_if.slot),
      .rsp_fired      (rsp_if.fired),
      .rsp_next_delay (rsp_if.next_delay),
      .rsp_last       (rsp_if.last)
   );

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("result written over a pending result");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("new transaction taken while busy");

   a_fire_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.fired) |-> (!rsp_if.last && rsp_if.status == att_pkg::ST_FIRED))
      else $error("fired result with bad status or last mark");

   a_fire_in_tick: assert property (@(posedge clock) disable iff (reset)
      cmd.fire_commit |-> (stat.mode == att_pkg::MODE_TICK))
      else $error("fire outside a tick");

endmodule

/* hw/rtl/att_ctrl.sv */
module att_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  att_pkg::stat_type  stat,
   output att_pkg::cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_REG_SCAN,
      S_TICK_SCAN,
      S_TICK_WAIT,
      S_TICK_DECIDE,
      S_TICK_FIRE,
      S_SUM_SCAN,
      S_SUM_WAIT,
      S_SUM_EMIT
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.kind = att_pkg::KIND_REG_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.mode)
               att_pkg::MODE_REGISTER: begin
                  if (stat.period_zero) begin
                     if (stat.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.kind = att_pkg::KIND_ZERO;
                        state_in = S_IDLE;
                     end
                  end else begin
                     cmd.scan_clr = 1'b1;
                     state_in     = S_REG_SCAN;
                  end
               end
               att_pkg::MODE_UNREGISTER: begin
                  if (stat.out_free) begin
                     cmd.emit = 1'b1;
                     if (stat.handle_ok) begin
                        cmd.unreg_clear = 1'b1;
                        cmd.kind        = att_pkg::KIND_REMOVED;
                     end else begin
                        cmd.kind = att_pkg::KIND_NO_ALARM;
                     end
                     state_in = S_IDLE;
                  end
               end
               att_pkg::MODE_TICK: begin
                  cmd.scan_clr = 1'b1;
                  cmd.tick_clr = 1'b1;
                  state_in     = S_TICK_SCAN;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_REG_SCAN: begin
            if (stat.cur_free) begin
               if (stat.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.reg_write = 1'b1;
                  cmd.kind      = att_pkg::KIND_REG_OK;
                  state_in      = S_IDLE;
               end
            end else if (stat.scan_last) begin
               if (stat.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.kind = att_pkg::KIND_FULL;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         S_TICK_SCAN: begin
            cmd.scan_inc  = 1'b1;
            cmd.mask_done = 1'b1;
            if (stat.scan_last) state_in = S_TICK_WAIT;
         end
         S_TICK_WAIT: begin
            cmd.mask_done = 1'b1;
            state_in      = S_TICK_DECIDE;
         end
         S_TICK_DECIDE: begin
            if (stat.fire_ok) begin
               cmd.rd_best = 1'b1;
               state_in    = S_TICK_FIRE;
            end else begin
               cmd.scan_clr = 1'b1;
               state_in     = S_SUM_SCAN;
            end
         end
         S_TICK_FIRE: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.kind        = att_pkg::KIND_FIRE;
               cmd.fire_commit = 1'b1;
               cmd.scan_clr    = 1'b1;
               state_in        = S_TICK_SCAN;
            end
         end
         S_SUM_SCAN: begin
            cmd.scan_inc = 1'b1;
            if (stat.scan_last) state_in = S_SUM_WAIT;
         end
         S_SUM_WAIT: begin
            state_in = S_SUM_EMIT;
         end
         S_SUM_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = att_pkg::KIND_SUMMARY;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/att_datapath.sv */
module att_datapath #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  att_pkg::cmd_type                cmd,
   output att_pkg::stat_type               stat,
   input  logic [att_pkg::MODE_W-1:0]      req_mode,
   input  logic [att_pkg::TIME_W-1:0]      req_now,
   input  logic [att_pkg::TIME_W-1:0]      req_period,
   input  logic                            req_repeat_req,
   input  logic [att_pkg::HANDLE_W-1:0]    req_handle,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [att_pkg::STATUS_W-1:0]    rsp_status,
   output logic [att_pkg::SLOT_W-1:0]      rsp_slot,
   output logic                            rsp_fired,
   output logic [att_pkg::TIME_W-1:0]      rsp_next_delay,
   output logic                            rsp_last
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam int TW    = att_pkg::TIME_W;

   function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
      logic [TW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TW] ? {TW{1'b1}} : s[TW-1:0];
   endfunction

   // latched transaction
   logic [att_pkg::MODE_W-1:0]   mode_ff;
   logic [TW-1:0]                now_ff;
   logic [TW-1:0]                period_ff;
   logic                         repeat_ff;
   logic [att_pkg::HANDLE_W-1:0] handle_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff   <= req_mode;
         now_ff    <= req_now;
         period_ff <= req_period;
         repeat_ff <= req_repeat_req;
         handle_ff <= req_handle;
      end
   end

   // slot storage
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [NUM_SLOTS-1:0] done_ff, done_in;
   logic                 rep_mem [NUM_SLOTS];
   logic [TW-1:0]        per_mem [NUM_SLOTS];
   logic [TW-1:0]        due_mem [NUM_SLOTS];
   logic                 rd_rep_ff;
   logic [TW-1:0]        rd_per_ff;
   logic [TW-1:0]        rd_due_ff;

   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             cmp_vld_ff;
   logic             best_found_ff, best_found_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [TW-1:0]    best_due_ff, best_due_in;
   logic [att_pkg::FIRE_CNT_W-1:0] fire_cnt_ff, fire_cnt_in;

   logic [IDX_W-1:0] handle_idx;
   logic [IDX_W-1:0] rd_addr;
   logic             rd_en;
   logic             due_we;
   logic [IDX_W-1:0] due_waddr;
   logic [TW-1:0]    due_wdata;
   logic             scan_last;
   logic             eligible;
   logic             handle_ok;
   logic [TW-1:0]    delay;
   logic             out_free;

   assign handle_idx = IDX_W'(handle_ff);
   assign handle_ok  = (32'(handle_ff) < 32'(NUM_SLOTS)) && valid_ff[handle_idx];
   assign scan_last  = (scan_idx_ff == IDX_W'(NUM_SLOTS - 1));
   assign rd_en      = cmd.scan_inc | cmd.rd_best;
   assign rd_addr    = cmd.rd_best ? best_idx_ff : scan_idx_ff;

   assign due_we    = cmd.reg_write | (cmd.fire_commit & rd_rep_ff);
   assign due_waddr = cmd.reg_write ? scan_idx_ff : best_idx_ff;
   assign due_wdata = cmd.reg_write ? sat_add(now_ff, period_ff) : sat_add(now_ff, rd_per_ff);

   always_ff @(posedge clock) begin
      if (cmd.reg_write) begin
         rep_mem[scan_idx_ff] <= repeat_ff;
         per_mem[scan_idx_ff] <= period_ff;
      end
      if (due_we) begin
         due_mem[due_waddr] <= due_wdata;
      end
      if (rd_en) begin
         rd_rep_ff <= rep_mem[rd_addr];
         rd_per_ff <= per_mem[rd_addr];
         rd_due_ff <= due_mem[rd_addr];
      end
      cmp_idx_ff <= scan_idx_ff;
   end

   assign eligible = cmp_vld_ff && valid_ff[cmp_idx_ff] &&
                     !(cmd.mask_done && done_ff[cmp_idx_ff]);

   always_comb begin
      valid_in = valid_ff;
      if (cmd.reg_write) valid_in[scan_idx_ff] = 1'b1;
      if (cmd.unreg_clear) valid_in[handle_idx] = 1'b0;
      if (cmd.fire_commit && !rd_rep_ff) valid_in[best_idx_ff] = 1'b0;

      done_in = done_ff;
      if (cmd.tick_clr) done_in = '0;
      if (cmd.fire_commit) done_in[best_idx_ff] = 1'b1;

      fire_cnt_in = fire_cnt_ff;
      if (cmd.tick_clr) fire_cnt_in = '0;
      else if (cmd.fire_commit) fire_cnt_in = fire_cnt_ff + 1'b1;

      scan_idx_in = scan_idx_ff;
      if (cmd.scan_clr) scan_idx_in = '0;
      else if (cmd.scan_inc && !scan_last) scan_idx_in = scan_idx_ff + 1'b1;

      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_due_in   = best_due_ff;
      if (cmd.scan_clr) begin
         best_found_in = 1'b0;
      end else if (eligible && (!best_found_ff || rd_due_ff < best_due_ff)) begin
         best_found_in = 1'b1;
         best_idx_in   = cmp_idx_ff;
         best_due_in   = rd_due_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         done_ff       <= '0;
         fire_cnt_ff   <= '0;
         scan_idx_ff   <= '0;
         cmp_vld_ff    <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         done_ff       <= done_in;
         fire_cnt_ff   <= fire_cnt_in;
         scan_idx_ff   <= scan_idx_in;
         cmp_vld_ff    <= cmd.scan_inc;
         best_found_ff <= best_found_in;
      end
      best_idx_ff <= best_idx_in;
      best_due_ff <= best_due_in;
   end

   always_comb begin
      if (!best_found_ff) delay = '0;
      else if (best_due_ff > now_ff) delay = best_due_ff - now_ff;
      else delay = TW'(1);
   end

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [att_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [att_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic                          fired_ff, fired_in;
   logic [TW-1:0]                 delay_ff, delay_in;
   logic                          last_ff, last_in;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      status_in = status_ff;
      slot_in   = slot_ff;
      fired_in  = fired_ff;
      delay_in  = delay_ff;
      last_in   = last_ff;
      if (cmd.emit) begin
         slot_in  = '0;
         fired_in = 1'b0;
         delay_in = '0;
         last_in  = 1'b1;
         case (cmd.kind)
            att_pkg::KIND_REG_OK: begin
               status_in = att_pkg::ST_REGISTERED;
               slot_in   = att_pkg::SLOT_W'(scan_idx_ff);
            end
            att_pkg::KIND_FULL: status_in = att_pkg::ST_FULL;
            att_pkg::KIND_ZERO: status_in = att_pkg::ST_ZERO;
            att_pkg::KIND_REMOVED: begin
               status_in = att_pkg::ST_REMOVED;
               slot_in   = handle_ff;
            end
            att_pkg::KIND_NO_ALARM: begin
               status_in = att_pkg::ST_NO_ALARM;
               slot_in   = handle_ff;
            end
            att_pkg::KIND_FIRE: begin
               status_in = att_pkg::ST_FIRED;
               slot_in   = att_pkg::SLOT_W'(best_idx_ff);
               fired_in  = 1'b1;
               last_in   = 1'b0;
            end
            att_pkg::KIND_SUMMARY: begin
               status_in = att_pkg::ST_FIRED;
               delay_in  = delay;
            end
            default: status_in = att_pkg::ST_NO_ALARM;
         endcase
      end
      rsp_valid_in = cmd.emit | (rsp_valid_ff & !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      slot_ff   <= slot_in;
      fired_ff  <= fired_in;
      delay_ff  <= delay_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_slot       = slot_ff;
   assign rsp_fired      = fired_ff;
   assign rsp_next_delay = delay_ff;
   assign rsp_last       = last_ff;

   assign stat.mode        = mode_ff;
   assign stat.period_zero = (period_ff == '0);
   assign stat.handle_ok   = handle_ok;
   assign stat.cur_free    = !valid_ff[scan_idx_ff];
   assign stat.scan_last   = scan_last;
   assign stat.fire_ok     = best_found_ff && (best_due_ff <= now_ff) &&
                             (fire_cnt_ff < att_pkg::FIRE_CNT_W'(att_pkg::MAX_FIRES));
   assign stat.out_free    = out_free;

endmodule
